[rtl/md5_pkg.sv]
// MD5 stream hash package: round constants, shift amounts, initial values.
// No dependencies.
package md5_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hEFCDAB89;
	localparam logic [31:0] INIT_C = 32'h98BADCFE;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	typedef logic [31:0] word_t;

	function automatic word_t round_k(input logic [5:0] i);
		word_t k;
		unique case (i)
			6'd0: k = 32'hD76AA478; 6'd1: k = 32'hE8C7B756; 6'd2: k = 32'h242070DB;
			6'd3: k = 32'hC1BDCEEE; 6'd4: k = 32'hF57C0FAF; 6'd5: k = 32'h4787C62A;
			6'd6: k = 32'hA8304613; 6'd7: k = 32'hFD469501; 6'd8: k = 32'h698098D8;
			6'd9: k = 32'h8B44F7AF; 6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
			6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193; 6'd14: k = 32'hA679438E;
			6'd15: k = 32'h49B40821; 6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
			6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA; 6'd20: k = 32'hD62F105D;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
			6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6; 6'd26: k = 32'hF4D50D87;
			6'd27: k = 32'h455A14ED; 6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
			6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A; 6'd32: k = 32'hFFFA3942;
			6'd33: k = 32'h8771F681; 6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
			6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9; 6'd38: k = 32'hF6BB4B60;
			6'd39: k = 32'hBEBFBC70; 6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
			6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05; 6'd44: k = 32'hD9D4D039;
			6'd45: k = 32'hE6DB99E5; 6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
			6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97; 6'd50: k = 32'hAB9423A7;
			6'd51: k = 32'hFC93A039; 6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
			6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1; 6'd56: k = 32'h6FA87E4F;
			6'd57: k = 32'hFE2CE6E0; 6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
			6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235; 6'd62: k = 32'h2AD7D2BB;
			default: k = 32'hEB86D391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_s(input logic [3:0] idx);
		logic [4:0] s;
		unique case (idx)
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

endpackage

[rtl/md5_if.sv]
// Valid/ready stream interfaces for the MD5 hash: byte input and digest output.
// Depends on nothing.
interface md5_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;
	modport source (output valid, data_byte, has_byte, last, input ready);
	modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

interface md5_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_high;
	logic [63:0] digest_low;
	modport source (output valid, digest_high, digest_low, input ready);
	modport sink (input valid, digest_high, digest_low, output ready);
endinterface

[rtl/md5_stream_hash.sv]
// MD5 stream hash top level: byte buffer, round sequencer, digest register.
// Depends on md5_pkg and the interfaces in md5_if.sv.
//
// Usage: the message arrives one beat per byte on in_ch (data_byte valid
// when has_byte is set; last closes the message, with or without a byte).
// A beat without byte and without last is dropped with no effect.
// A beat leaves the input open unless it fills the 64-byte block buffer or
// closes the message. A full block is compressed one MD5 round per cycle
// through a single shared adder-and-rotate unit, then the result is folded
// into the chaining words. A closing beat sweeps the rest of the buffer one
// byte per cycle (pad byte, zeros, length) and compresses once or twice
// (twice when fewer than eight bytes stay free after the pad byte), then
// hands the digest to out_ch. The round unit reads the buffer at one word
// address per cycle.
// in_ch.ready is low while padding and compressing. A waiting digest sits
// in its own register, so the next message streams in meanwhile; if it
// closes while the receiver still stalls, hold it at the output step and
// keep the input off until the first digest is taken.
// Reset (arst_n low) loads the MD5 initial values and clears the count;
// the block buffer keeps no reset and is only read where written.
module md5_stream_hash (
	input  logic             clk,
	input  logic             arst_n,
	md5_in_if.sink           in_ch,
	md5_out_if.source        out_ch
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_FOLD  = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	md5_pkg::word_t cw_q [4];
	md5_pkg::word_t a_q, b_q, c_q, d_q;
	logic [63:0] bits_q;
	logic [5:0]  round_q;
	logic        fin_q;     // compressing a padded block; also stops a second pad byte
	logic        second_q;  // the compression under way is the final one (or a pad is pending)
	logic [31:0] buf_q [16];
	logic [5:0]  clr_q;     // next byte to write while padding
	logic [127:0] dig_q;
	logic        ovalid_q;

	logic [5:0]  pos;
	logic        take;
	logic        out_free;
	logic [1:0]  phase;
	logic [3:0]  g;
	md5_pkg::word_t w, f, sum, rot;
	logic [4:0]  s;

	assign pos   = bits_q[8:3];
	assign take  = in_ch.valid & in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_free = ~ovalid_q | out_ch.ready;
	assign phase = round_q[5:4];

	always_comb begin
		unique case (phase)
			2'd0: begin f = d_q ^ (b_q & (c_q ^ d_q)); g = round_q[3:0]; end
			2'd1: begin f = c_q ^ (d_q & (b_q ^ c_q)); g = 4'(5 * round_q + 1); end
			2'd2: begin f = b_q ^ c_q ^ d_q;           g = 4'(3 * round_q + 5); end
			default: begin f = c_q ^ (b_q | ~d_q);     g = 4'(7 * round_q); end
		endcase
		w   = buf_q[g];
		s   = md5_pkg::rot_s({phase, round_q[1:0]});
		sum = a_q + f + md5_pkg::round_k(round_q) + w;
		rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
	end

	// Buffer writes: message bytes, pad/zero sweep, length bytes.
	always_ff @(posedge clk) begin
		if (take && in_ch.has_byte) begin
			buf_q[pos[5:2]][{pos[1:0], 3'd0} +: 8] <= in_ch.data_byte;
		end else if (state_q == ST_PAD) begin
			if (clr_q >= 6'd56 && second_q)
				buf_q[clr_q[5:2]][{clr_q[1:0], 3'd0} +: 8] <=
					bits_q[{clr_q[2:0], 3'd0} +: 8];
			else
				buf_q[clr_q[5:2]][{clr_q[1:0], 3'd0} +: 8] <=
					(clr_q == pos && !fin_q) ? md5_pkg::PAD_BYTE : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cw_q[0]  <= md5_pkg::INIT_A;
			cw_q[1]  <= md5_pkg::INIT_B;
			cw_q[2]  <= md5_pkg::INIT_C;
			cw_q[3]  <= md5_pkg::INIT_D;
			a_q      <= '0;
			b_q      <= '0;
			c_q      <= '0;
			d_q      <= '0;
			bits_q   <= '0;
			round_q  <= '0;
			fin_q    <= 1'b0;
			second_q <= 1'b0;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ch.ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						// last with a full block: compress first, pad after
						if (in_ch.has_byte) bits_q <= bits_q + 64'd8;
						fin_q    <= 1'b0;
						second_q <= 1'b0;
						round_q  <= '0;
						a_q <= cw_q[0]; b_q <= cw_q[1]; c_q <= cw_q[2]; d_q <= cw_q[3];
						if (in_ch.has_byte && pos == 6'd63) begin
							state_q <= ST_ROUND;
							second_q <= in_ch.last; // reuse as "pad pending"
						end else if (in_ch.last) begin
							state_q <= ST_PAD;
							clr_q   <= in_ch.has_byte ? pos + 6'd1 : pos;
							second_q <= (in_ch.has_byte ? pos + 6'd1 : pos) < 6'd56
								&& !(in_ch.has_byte && pos == 6'd63);
						end
					end
				end
				ST_PAD: begin
					// sweep up to byte 63, then compress
					clr_q <= clr_q + 6'd1;
					if (clr_q == 6'd63) begin
						state_q <= ST_ROUND;
						fin_q   <= 1'b1;
						round_q <= '0;
						a_q <= cw_q[0]; b_q <= cw_q[1]; c_q <= cw_q[2]; d_q <= cw_q[3];
					end
				end
				ST_ROUND: begin
					a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					cw_q[0] <= cw_q[0] + a_q; cw_q[1] <= cw_q[1] + b_q;
					cw_q[2] <= cw_q[2] + c_q; cw_q[3] <= cw_q[3] + d_q;
					round_q <= '0;
					if (!fin_q) begin
						// a full block; a pending close pads a fresh block
						if (second_q) begin
							state_q <= ST_PAD; clr_q <= '0;
							second_q <= 1'b1; fin_q <= 1'b0;
						end else state_q <= ST_IDLE;
					end else if (!second_q) begin
						state_q <= ST_PAD; clr_q <= '0;
						second_q <= 1'b1; fin_q <= 1'b1;
					end else state_q <= ST_OUT;
				end
				default: begin
					// ST_OUT: hold until the digest register frees, then load
					// the digest and restart the message
					if (out_free) begin
						ovalid_q <= 1'b1;
						cw_q[0]  <= md5_pkg::INIT_A;
						cw_q[1]  <= md5_pkg::INIT_B;
						cw_q[2]  <= md5_pkg::INIT_C;
						cw_q[3]  <= md5_pkg::INIT_D;
						bits_q   <= '0;
						fin_q    <= 1'b0;
						second_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free)
			dig_q <= {cw_q[0][7:0], cw_q[0][15:8], cw_q[0][23:16], cw_q[0][31:24],
			          cw_q[1][7:0], cw_q[1][15:8], cw_q[1][23:16], cw_q[1][31:24],
			          cw_q[2][7:0], cw_q[2][15:8], cw_q[2][23:16], cw_q[2][31:24],
			          cw_q[3][7:0], cw_q[3][15:8], cw_q[3][23:16], cw_q[3][31:24]};
	end

	assign out_ch.valid       = ovalid_q;
	assign out_ch.digest_high = dig_q[127:64];
	assign out_ch.digest_low  = dig_q[63:0];

endmodule

[rtl/md5_chk.sv]
// Port-level checker for md5_stream_hash, with its bind statement.
// Depends on md5_stream_hash, its bind target, and the interfaces in md5_if.sv.
module md5_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_high
);

	// a closing beat keeps the input off in the next cycle
	a_busy_close: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> !in_ready) else $error("input open after close");

	// a closing beat cannot give a digest in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last && !out_valid) |=> !out_valid)
		else $error("digest too early");

	// a waiting digest holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_high)))
		else $error("digest dropped");

endmodule

bind md5_stream_hash md5_chk u_md5_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_last   (in_ch.last),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_high  (out_ch.digest_high)
);
